@@ rtl/vtcw_pkg.sv @@
`default_nettype none

package vtcw_pkg;

   localparam int KIND_W = 2;
   localparam int CON_W  = 3;
   localparam int CHAR_W = 8;
   localparam int ROW_W  = 5;
   localparam int COL_W  = 7;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;

   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUT    = 2'd0,
      KIND_CLEAR  = 2'd1,
      KIND_SELECT = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

endpackage

`default_nettype wire

@@ rtl/vtcw_ram.sv @@
`default_nettype none

module vtcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8000,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/virtual_text_console_writer.sv @@
// Multi-console text screen writer, one cell store in a single RAM.
// An accepted request goes to ST_EXEC, then to ST_FINISH, which registers the response;
// a clear adds an ST_FILL pass over the screen, a scroll an ST_COPY pass, then ST_FILL.
// ST_FINISH waits while an earlier response is not yet taken; one item in flight.
// Reset: synchronous; afterwards a blanking pass of all CONSOLES*ROWS*COLUMNS cells
// (8000 by default) runs with req_ready low. CSR writes are taken throughout.
`default_nettype none

module virtual_text_console_writer #(
   parameter int CONSOLES = 4,
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write_enable,
   input  logic [vtcw_pkg::ATTR_W-1:0] csr_write_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [vtcw_pkg::KIND_W-1:0] req_kind,
   input  logic [vtcw_pkg::CON_W-1:0]  req_console_index,
   input  logic [vtcw_pkg::CHAR_W-1:0] req_char_code,
   input  logic [vtcw_pkg::ROW_W-1:0]  req_cell_row,
   input  logic [vtcw_pkg::COL_W-1:0]  req_cell_col,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [vtcw_pkg::CELL_W-1:0] rsp_cell_value,
   output logic [vtcw_pkg::COL_W-1:0]  rsp_cursor_col,
   output logic [vtcw_pkg::ROW_W-1:0]  rsp_cursor_row,
   output logic [vtcw_pkg::CON_W-1:0]  rsp_shown_console,
   output logic                        rsp_rejected
);

   import vtcw_pkg::*;

   localparam int SCREEN = ROWS * COLUMNS;
   localparam int DEPTH  = CONSOLES * SCREEN;
   localparam int AW     = $clog2(DEPTH);
   localparam int CW     = $clog2(COLUMNS);
   localparam int RW     = $clog2(ROWS);
   localparam int IW     = (CONSOLES > 1) ? $clog2(CONSOLES) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);
   localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_FILL,
      ST_FINISH
   } state_type;

   state_type         state_ff, state_in;
   kind_type          kind_ff, kind_in;
   logic [CON_W-1:0]  con_ff, con_in;
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [ROW_W-1:0]  cell_row_ff, cell_row_in;
   logic [COL_W-1:0]  cell_col_ff, cell_col_in;
   logic              read_ok_ff, read_ok_in;
   logic              rej_ff, rej_in;
   logic [AW-1:0]     base_ff, base_in;
   logic [AW-1:0]     last_ff, last_in;
   logic [AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic              rd_done_ff, rd_done_in;
   logic              pend_ff, pend_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [CON_W-1:0]  sel_ff, sel_in;
   logic [CW-1:0]     cur_col_ff [CONSOLES];
   logic [CW-1:0]     cur_col_in [CONSOLES];
   logic [RW-1:0]     cur_row_ff [CONSOLES];
   logic [RW-1:0]     cur_row_in [CONSOLES];
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_cell_ff, rsp_cell_in;
   logic [COL_W-1:0]  rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0]  rsp_row_ff, rsp_row_in;
   logic [CON_W-1:0]  rsp_shown_ff, rsp_shown_in;
   logic              rsp_rej_ff, rsp_rej_in;

   logic [IW-1:0]       con_idx;
   logic [CW-1:0]       col_now;
   logic [RW-1:0]       row_now;
   logic [CW-1:0]       put_col;
   logic                put_step;
   logic [AW-1:0]       cur_pos;
   logic [AW-1:0]       read_pos;
   logic [CW+COL_W-1:0] col_ext;
   logic [RW+ROW_W-1:0] row_ext;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [CELL_W-1:0] mem_wdata;
   logic              mem_re;
   logic [AW-1:0]     mem_raddr;
   logic [CELL_W-1:0] mem_rdata;

   vtcw_ram #(
      .WIDTH(CELL_W),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign con_idx  = con_ff[IW-1:0];
   assign col_now  = cur_col_ff[con_idx];
   assign row_now  = cur_row_ff[con_idx];
   assign cur_pos  = AW'(int'(base_ff) + int'(row_now) * COLUMNS + int'(col_now));
   assign read_pos = AW'(int'(base_ff) + int'(cell_row_ff) * COLUMNS + int'(cell_col_ff));
   assign col_ext  = {{COL_W{1'b0}}, col_now};
   assign row_ext  = {{ROW_W{1'b0}}, row_now};

   assign req_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_cell_ff;
   assign rsp_cursor_col    = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_shown_console = rsp_shown_ff;
   assign rsp_rejected      = rsp_rej_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      con_in       = con_ff;
      char_in      = char_ff;
      cell_row_in  = cell_row_ff;
      cell_col_in  = cell_col_ff;
      read_ok_in   = read_ok_ff;
      rej_in       = rej_ff;
      base_in      = base_ff;
      last_in      = last_ff;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_done_in   = rd_done_ff;
      pend_in      = pend_ff;
      attr_in      = attr_ff;
      sel_in       = sel_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cell_in  = rsp_cell_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_shown_in = rsp_shown_ff;
      rsp_rej_in   = rsp_rej_ff;
      put_col      = col_now;
      put_step     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = wr_ptr_ff;
      mem_wdata    = BLANK_CELL;
      mem_re       = 1'b0;
      mem_raddr    = rd_ptr_ff;

      if (csr_write_enable) begin
         attr_in = csr_write_data;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            if (wr_ptr_ff == LAST_ADDR) begin
               wr_ptr_in = '0;
               state_in  = ST_IDLE;
            end else begin
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in     = kind_type'(req_kind);
               con_in      = req_console_index;
               char_in     = req_char_code;
               cell_row_in = req_cell_row;
               cell_col_in = req_cell_col;
               read_ok_in  = (32'(req_cell_row) < ROWS) && (32'(req_cell_col) < COLUMNS);
               rej_in      = (32'(req_console_index) >= CONSOLES);
               base_in     = AW'(int'(req_console_index) * SCREEN);
               last_in     = AW'((int'(req_console_index) + 1) * SCREEN - 1);
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_FINISH;
            if (!rej_ff) begin
               case (kind_ff)
                  KIND_PUT: begin
                     if (char_ff != CHAR_NUL) begin
                        if (char_ff == CHAR_NEWLINE) begin
                           put_col  = '0;
                           put_step = 1'b1;
                        end else begin
                           mem_we    = 1'b1;
                           mem_waddr = cur_pos;
                           mem_wdata = {attr_ff, char_ff};
                           if (col_now == LAST_COL) begin
                              put_col  = '0;
                              put_step = 1'b1;
                           end else begin
                              put_col = col_now + 1'b1;
                           end
                        end
                        cur_col_in[con_idx] = put_col;
                        if (put_step) begin
                           if (row_now == LAST_ROW) begin
                              // scroll: copy rows up, then blank the last row
                              rd_ptr_in  = AW'(int'(base_ff) + COLUMNS);
                              wr_ptr_in  = base_ff;
                              rd_done_in = 1'b0;
                              pend_in    = 1'b0;
                              state_in   = ST_COPY;
                           end else begin
                              cur_row_in[con_idx] = row_now + 1'b1;
                           end
                        end
                     end
                  end
                  KIND_CLEAR: begin
                     cur_col_in[con_idx] = '0;
                     cur_row_in[con_idx] = '0;
                     wr_ptr_in           = base_ff;
                     state_in            = ST_FILL;
                  end
                  KIND_SELECT: begin
                     sel_in = con_ff;
                  end
                  KIND_READ: begin
                     if (read_ok_ff) begin
                        mem_re    = 1'b1;
                        mem_raddr = read_pos;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_COPY: begin
            pend_in = !rd_done_ff;
            if (!rd_done_ff) begin
               mem_re    = 1'b1;
               rd_ptr_in = rd_ptr_ff + 1'b1;
               if (rd_ptr_ff == last_ff) begin
                  rd_done_in = 1'b1;
               end
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rdata;
               wr_ptr_in = wr_ptr_ff + 1'b1;
               if (rd_done_ff) begin
                  state_in = ST_FILL;
               end
            end
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (wr_ptr_ff == last_ff) begin
               state_in = ST_FINISH;
            end else begin
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_shown_in = sel_ff;
               rsp_rej_in   = rej_ff;
               if (rej_ff) begin
                  rsp_cell_in = '0;
                  rsp_col_in  = '0;
                  rsp_row_in  = '0;
               end else begin
                  rsp_cell_in = (kind_ff == KIND_READ && read_ok_ff) ? mem_rdata : '0;
                  rsp_col_in  = col_ext[COL_W-1:0];
                  rsp_row_in  = row_ext[ROW_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         wr_ptr_ff    <= '0;
         rd_done_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         attr_ff      <= ATTR_RESET;
         sel_ff       <= '0;
         cur_col_ff   <= '{default: '0};
         cur_row_ff   <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_done_ff   <= rd_done_in;
         pend_ff      <= pend_in;
         attr_ff      <= attr_in;
         sel_ff       <= sel_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         con_ff       <= con_in;
         char_ff      <= char_in;
         cell_row_ff  <= cell_row_in;
         cell_col_ff  <= cell_col_in;
         read_ok_ff   <= read_ok_in;
         rej_ff       <= rej_in;
         base_ff      <= base_in;
         last_ff      <= last_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_cell_ff  <= rsp_cell_in;
         rsp_col_ff   <= rsp_col_in;
         rsp_row_ff   <= rsp_row_in;
         rsp_shown_ff <= rsp_shown_in;
         rsp_rej_ff   <= rsp_rej_in;
      end
   end

endmodule

`default_nettype wire
